@@ design/assert_macros.svh @@
// Assertion macros used by the back end; empty when building for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPQ_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rpq assertion failed");
`define RPQ_ASSERT_RESET(label, sig) \
    label: assert property (@(posedge aclk) !aresetn |=> !(sig)) \
        else $error("rpq reset assertion failed");
`else
`define RPQ_ASSERT(label, prop)
`define RPQ_ASSERT_RESET(label, sig)
`endif
`endif

@@ design/rpq_pkg.sv @@
// Types, constants and the symbol reduction table of the read packer.
package rpq_pkg;

    localparam int SYMBOLS_PER_WORD = 32;
    localparam int WORD_W           = 2 * SYMBOLS_PER_WORD;
    localparam int COUNT_W          = $clog2(SYMBOLS_PER_WORD + 1);
    localparam int FILL_W           = $clog2(SYMBOLS_PER_WORD);
    localparam int QSUM_W           = 13;
    localparam int DIV_STEPS        = QSUM_W;
    localparam int STEP_W           = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [7:0] QUALITY_ABSENT = 8'd127;
    localparam logic [7:0] CASE_OFFSET    = 8'd32;

    typedef struct packed {
        logic [7:0] base;
        logic [7:0] quality;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  packed_word;
        logic [7:0]         avg_quality;
        logic [COUNT_W-1:0] symbol_count;
        logic               bad_symbol;
        logic               final_word;
    } out_item_t;

    // One finished word handed from the front to the back.
    typedef struct packed {
        logic [WORD_W-1:0]  packed_word;
        logic [QSUM_W-1:0]  quality_sum;
        logic [COUNT_W-1:0] symbol_count;
        logic               bad_symbol;
        logic               final_word;
    } job_t;

    // Returns {hit, code}; hit is 0 for characters outside the table.
    function automatic logic [2:0] reduce_char(input logic [7:0] ch);
        logic [7:0] up;
        logic [2:0] res;
        up = ch;
        if (ch inside {[8'd97:8'd122]}) begin
            up = ch - CASE_OFFSET;
        end
        case (up)
            "-", "A", "D", "N", "R", "W": res = 3'b100;
            "B", "C", "M", "S":           res = 3'b101;
            "G", "K", "V":                res = 3'b110;
            "H", "T", "U", "Y":           res = 3'b111;
            default:                      res = 3'b000;
        endcase
        return res;
    endfunction

endpackage

@@ design/rpq_queue.sv @@
// Short queue of finished words between the packing front and the averaging back.
module rpq_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  rpq_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rpq_pkg::job_t pop_data
);
    import rpq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb begin
        push_ready = (count_reg != CNT_W'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_data   = mem[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/rpq_front.sv @@
// Front end: reduces each character to a code and gathers codes into left-aligned words.
module rpq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpq_pkg::in_item_t s_data,
    output logic              job_valid,
    input  logic              job_ready,
    output rpq_pkg::job_t     job
);
    import rpq_pkg::*;

    logic [WORD_W-1:0]  shift_reg, shift_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [QSUM_W-1:0]  qsum_reg, qsum_next;
    logic               bad_reg, bad_next;

    logic [2:0]         red;
    logic               accept, emit;
    logic [WORD_W-1:0]  word_ins;
    logic [QSUM_W-1:0]  sum_ins;
    logic [COUNT_W-1:0] count_ins;
    logic               bad_ins;

    always_comb begin
        red       = reduce_char(s_data.base);
        s_ready   = job_ready;
        accept    = s_valid && s_ready;
        // The word is built already left-aligned: symbol n lands at bits 63-2n.
        word_ins  = shift_reg | ({red[1:0], {(WORD_W-2){1'b0}}} >> {fill_reg, 1'b0});
        sum_ins   = qsum_reg + QSUM_W'(s_data.quality);
        count_ins = COUNT_W'({1'b0, fill_reg}) + COUNT_W'(1);
        bad_ins   = bad_reg || !red[2];
        emit      = s_data.last || (fill_reg == FILL_W'(SYMBOLS_PER_WORD - 1));

        job_valid        = accept && emit;
        job.packed_word  = word_ins;
        job.quality_sum  = sum_ins;
        job.symbol_count = count_ins;
        job.bad_symbol   = bad_ins;
        job.final_word   = s_data.last;

        shift_next = shift_reg;
        fill_next  = fill_reg;
        qsum_next  = qsum_reg;
        bad_next   = bad_reg;
        if (accept) begin
            if (emit) begin
                shift_next = '0;
                fill_next  = '0;
                qsum_next  = '0;
                bad_next   = 1'b0;
            end else begin
                shift_next = word_ins;
                fill_next  = fill_reg + FILL_W'(1);
                qsum_next  = sum_ins;
                bad_next   = bad_ins;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            fill_reg  <= '0;
            qsum_reg  <= '0;
            bad_reg   <= 1'b0;
        end else begin
            shift_reg <= shift_next;
            fill_reg  <= fill_next;
            qsum_reg  <= qsum_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

@@ design/rpq_back.sv @@
// Back end: divides the quality sum by the symbol count and holds the result word.
module rpq_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               quality_enable,
    input  logic               job_valid,
    output logic               job_ready,
    input  rpq_pkg::job_t      job,
    output logic               m_valid,
    input  logic               m_ready,
    output rpq_pkg::out_item_t m_data
);
    import rpq_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [QSUM_W-1:0]  quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    job_t               job_reg, job_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic [COUNT_W:0]   trial, diff;
    logic               fits, out_free;

    always_comb begin
        // Restoring division, one quotient bit per cycle.
        trial    = {rem_reg, quo_reg[QSUM_W-1]};
        diff     = trial - {1'b0, job_reg.symbol_count};
        fits     = (trial >= {1'b0, job_reg.symbol_count});
        out_free = !out_valid_reg || m_ready;

        job_ready      = (state_reg == ST_IDLE);
        state_next     = state_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_next   = job;
                    quo_next   = job.quality_sum;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next = {quo_reg[QSUM_W-2:0], fits};
                rem_next = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    out_next.packed_word  = job_reg.packed_word;
                    out_next.avg_quality  = quality_enable ? quo_reg[7:0] : QUALITY_ABSENT;
                    out_next.symbol_count = job_reg.symbol_count;
                    out_next.bad_symbol   = job_reg.bad_symbol;
                    out_next.final_word   = job_reg.final_word;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid = out_valid_reg;
        m_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        job_reg <= job_next;
        out_reg <= out_next;
    end

    `RPQ_ASSERT(a_step_bound, state_reg == ST_DIV |-> step_reg < STEP_W'(DIV_STEPS))
    `RPQ_ASSERT(a_rem_below_divisor, state_reg == ST_DIV |-> rem_reg < job_reg.symbol_count)
    `RPQ_ASSERT(a_count_range, state_reg != ST_IDLE |-> job_reg.symbol_count != '0 && job_reg.symbol_count <= COUNT_W'(SYMBOLS_PER_WORD))
    `RPQ_ASSERT(a_load_from_done, !$past(out_valid_reg) && out_valid_reg |-> $past(state_reg) == ST_DONE)
    `RPQ_ASSERT_RESET(a_reset_out, out_valid_reg)

endmodule

@@ design/read_packer_with_quality_average.sv @@
// Top level of the two-bit read packer with per-word average quality.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_data  (base, quality, last)
//   m_       out        m_valid / m_ready    m_data  (word, average, count, flags)
//   cfg_     in         cfg_valid / cfg_ready cfg_data (quality_enable)
//
// The front takes one character per cycle while the word queue has room.
// Each emitted word passes through the back in order: it is taken from the queue,
// put through 13 restoring division steps (one per bit of the quality sum), and
// loaded into the output register once free; only then is a new word taken.
// Reset is synchronous with no clearing pass; queue and back data are not cleared.
// A stalled output holds its word; the front keeps packing until the queue is full.
module read_packer_with_quality_average #(
    parameter int QUEUE_DEPTH = rpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rpq_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import rpq_pkg::*;

    logic quality_enable_reg, quality_enable_next;
    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_job, pop_job;

    always_comb begin
        cfg_ready           = 1'b1;
        quality_enable_next = (cfg_valid && cfg_ready) ? cfg_data : quality_enable_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_enable_reg <= 1'b1;
        end else begin
            quality_enable_reg <= quality_enable_next;
        end
    end

    rpq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    rpq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    rpq_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .quality_enable (quality_enable_reg),
        .job_valid      (pop_valid),
        .job_ready      (pop_ready),
        .job            (pop_job),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the two-bit read packer with per-word average quality.
`timescale 1ns / 1ps

module tb;
    import rpq_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_FROM = 3000;
    localparam int QUIET_TO = 6000;
    localparam int MAX_REPORTS = 10;

    localparam int Q_PHRED = 0;
    localparam int Q_FULL = 1;
    localparam int Q_TOP = 2;
    localparam int Q_ZERO = 3;

    localparam string TABLE_CHARS = "-ADNRWBCMSGKVHTUYadnrwbcmsgkvhtuy";

    typedef struct packed {
        logic     hold;
        in_item_t item;
    } char_slot_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    char_slot_t char_queue[$];
    out_item_t word_queue[$];

    int cycles = 0;
    int in_sent = 0;
    int in_taken = 0;
    int errors = 0;

    // Software copy of the packer state.
    logic [WORD_W-1:0] pk_word = '0;
    int pk_fill = 0;
    logic [QSUM_W-1:0] pk_qsum = '0;
    logic pk_bad = 1'b0;
    logic qual_en = 1'b1;

    read_packer_with_quality_average u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Returns {mapped, code}.
    function automatic logic [2:0] code_of(input logic [7:0] ch);
        logic [7:0] up;
        up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
        case (up)
            "-", "A", "D", "N", "R", "W": return 3'b100;
            "B", "C", "M", "S": return 3'b101;
            "G", "K", "V": return 3'b110;
            "H", "T", "U", "Y": return 3'b111;
            default: return 3'b000;
        endcase
    endfunction

    function automatic void absorb_char(input in_item_t c);
        logic [2:0] hc;
        out_item_t w;
        hc = code_of(c.base);
        if (!hc[2]) begin
            pk_bad = 1'b1;
        end
        pk_word = {pk_word[WORD_W-3:0], hc[1:0]};
        pk_fill++;
        pk_qsum = pk_qsum + QSUM_W'(c.quality);
        if (pk_fill == SYMBOLS_PER_WORD || c.last) begin
            w.packed_word = pk_word << (2 * (SYMBOLS_PER_WORD - pk_fill));
            w.avg_quality = qual_en ? 8'(int'(pk_qsum) / pk_fill) : QUALITY_ABSENT;
            w.symbol_count = COUNT_W'(pk_fill);
            w.bad_symbol = pk_bad;
            w.final_word = c.last;
            word_queue.push_back(w);
            pk_word = '0;
            pk_fill = 0;
            pk_qsum = '0;
            pk_bad = 1'b0;
        end
    endfunction

    function automatic logic roll_idle();
        if (cycles >= QUIET_FROM && cycles < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 9;
    endfunction

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Accepted characters feed the predictor; register writes update its copy.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            absorb_char(s_data);
            in_taken++;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            qual_en = cfg_data;
        end
    end

    always @(negedge aclk) begin
        char_slot_t nxt;
        logic go;
        if (!(s_valid && in_taken != in_sent)) begin
            go = 1'b0;
            if (char_queue.size() != 0 && !roll_idle()) begin
                nxt = char_queue[0];
                // A held character waits until the output side has caught up.
                go = !nxt.hold || word_queue.size() == 0;
            end
            if (go) begin
                nxt = char_queue.pop_front();
                s_data <= nxt.item;
                s_valid <= 1'b1;
                in_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= !roll_idle();
    end

    always @(posedge aclk) begin
        out_item_t want_w;
        logic bad;
        if (aresetn && m_valid && m_ready) begin
            if (word_queue.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("unexpected word %h avg %0d count %0d bad %b end %b",
                             m_data.packed_word, m_data.avg_quality, m_data.symbol_count,
                             m_data.bad_symbol, m_data.final_word);
                end
                errors++;
            end else begin
                want_w = word_queue.pop_front();
                bad = (m_data.packed_word !== want_w.packed_word)
                    || (m_data.avg_quality !== want_w.avg_quality)
                    || (m_data.symbol_count !== want_w.symbol_count)
                    || (m_data.bad_symbol !== want_w.bad_symbol)
                    || (m_data.final_word !== want_w.final_word);
                if (bad) begin
                    if (errors < MAX_REPORTS) begin
                        $display("word mismatch: want %h/%0d/%0d/%b/%b got %h/%0d/%0d/%b/%b",
                                 want_w.packed_word, want_w.avg_quality,
                                 want_w.symbol_count, want_w.bad_symbol, want_w.final_word,
                                 m_data.packed_word, m_data.avg_quality,
                                 m_data.symbol_count, m_data.bad_symbol, m_data.final_word);
                    end
                    errors++;
                end
            end
        end
    end

    function automatic void push_char(input logic [7:0] b, input logic [7:0] q,
                                      input logic lst, input logic hld = 1'b0);
        char_slot_t s;
        s.hold = hld;
        s.item.base = b;
        s.item.quality = q;
        s.item.last = lst;
        char_queue.push_back(s);
    endfunction

    function automatic logic [7:0] pick_quality(input int mode);
        case (mode)
            Q_PHRED: return 8'($urandom_range(74, 33));
            Q_FULL: return 8'($urandom_range(255));
            Q_TOP: return 8'd255;
            default: return 8'd0;
        endcase
    endfunction

    function automatic void push_read(input string seq, input int mode);
        for (int i = 0; i < seq.len(); i++) begin
            push_char(seq[i], pick_quality(mode), i == seq.len() - 1);
        end
    endfunction

    // Random reads: mostly clean table characters, some noisy, lengths that
    // land on and around word boundaries.
    function automatic void gen_reads(input int n_items);
        int done;
        int len;
        int r;
        int mode;
        int noisy;
        int nreads;
        logic [7:0] b;
        done = 0;
        nreads = 0;
        while (done < n_items) begin
            r = $urandom_range(99);
            if (r < 60) begin
                len = $urandom_range(40, 1);
            end else if (r < 80) begin
                len = 32 * $urandom_range(3, 1);
            end else if (r < 90) begin
                len = $urandom_range(1) ? 31 : 33;
            end else begin
                len = $urandom_range(120, 41);
            end
            r = $urandom_range(99);
            mode = (r < 60) ? Q_PHRED : (r < 80) ? Q_FULL : (r < 90) ? Q_TOP : Q_ZERO;
            noisy = $urandom_range(99) < 20;
            for (int i = 0; i < len; i++) begin
                if (noisy && $urandom_range(99) < 30) begin
                    b = 8'($urandom_range(255));
                end else begin
                    b = TABLE_CHARS[$urandom_range(TABLE_CHARS.len() - 1)];
                end
                push_char(b, pick_quality(mode), i == len - 1,
                          i == 0 && (nreads % 25 == 0));
            end
            done += len;
            nreads++;
        end
    endfunction

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (char_queue.size() != 0 || in_taken != in_sent || word_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_quality_enable(input logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed reads with the reset setting (quality enabled).
        push_read("-aDnRw", Q_ZERO);
        push_read("BcMsGkVhTuY", Q_TOP);
        push_char(8'h00, 8'hFF, 1'b0);
        push_char(8'hFF, 8'h00, 1'b1);
        // Characters at and just outside the edges of the letter ranges, none in the table.
        push_char(8'h40, pick_quality(Q_FULL), 1'b0);
        push_char(8'h5B, pick_quality(Q_FULL), 1'b0);
        push_char(8'h60, pick_quality(Q_FULL), 1'b0);
        push_char(8'h7A, pick_quality(Q_FULL), 1'b0);
        push_char(8'h7B, pick_quality(Q_FULL), 1'b1);
        push_char("a", 8'd200, 1'b1);
        wait_idle();

        write_quality_enable(1'b0);
        gen_reads(350);
        wait_idle();

        write_quality_enable(1'b1);
        gen_reads(700);
        wait_idle();

        write_quality_enable(1'b0);
        gen_reads(100);
        wait_idle();

        write_quality_enable(1'b1);
        gen_reads(300);
        wait_idle();

        if (errors == 0 && word_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
